@@ src/spirm_pkg.sv @@
// Shared types and constants for the SPI register-access master.
// Used by spirm_ctrl, spirm_datapath and spi_register_access_master_core.
package spirm_pkg;

  localparam int NUM_SELECTS = 2;
  localparam logic [NUM_SELECTS-1:0] SEL_ALL = '1;

  localparam logic [1:0] ACT_RAW   = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [1:0] CFG_ENABLE       = 2'd0;
  localparam logic [1:0] CFG_WRITE_PREFIX = 2'd1;
  localparam logic [1:0] CFG_READ_PREFIX  = 2'd2;
  localparam logic [1:0] CFG_ADDR_MASK    = 2'd3;

  localparam logic [3:0] LAST_BIT = 4'd7;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_LOAD,
    DP_START_CMD,
    DP_START_DATA,
    DP_BIT_LO,
    DP_BIT_HI,
    DP_FINISH
  } dp_op_t;

  typedef struct packed {
    logic enable;
    logic do_cmd;
    logic do_data;
    logic last_bit;
    logic out_full;
  } dp_status_t;

endpackage

@@ src/spirm_ctrl.sv @@
// Sequencer for the SPI register-access master: steps each item through
// command byte, data byte and finish. Depends on spirm_pkg.
module spirm_ctrl import spirm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  dp_status_t status,
  output dp_op_t     op
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_LO,
    S_HI,
    S_DATA,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   phase_cmd;
  logic   phase_cmd_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    phase_cmd_next = phase_cmd;
    op             = DP_NOP;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          op         = DP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        priority if (!status.enable) begin
          state_next = S_FINISH;
        end else if (status.do_cmd) begin
          op             = DP_START_CMD;
          phase_cmd_next = 1'b1;
          state_next     = S_LO;
        end else if (status.do_data) begin
          op             = DP_START_DATA;
          phase_cmd_next = 1'b0;
          state_next     = S_LO;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_LO: begin
        op         = DP_BIT_LO;
        state_next = S_HI;
      end
      S_HI: begin
        op = DP_BIT_HI;
        if (status.last_bit) begin
          state_next = (phase_cmd && status.do_data) ? S_DATA : S_FINISH;
        end else begin
          state_next = S_LO;
        end
      end
      S_DATA: begin
        op             = DP_START_DATA;
        phase_cmd_next = 1'b0;
        state_next     = S_LO;
      end
      S_FINISH: begin
        // hold until the result register is free
        if (!status.out_full) begin
          op         = DP_FINISH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase_cmd <= 1'b0;
    end else begin
      state     <= state_next;
      phase_cmd <= phase_cmd_next;
    end
  end

endmodule

@@ src/spirm_datapath.sv @@
// Datapath of the SPI register-access master: config registers, chip
// selects, shift registers, SCK/MOSI and the result register. Uses spirm_pkg.
module spirm_datapath import spirm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  dp_op_t     op,
  input  logic [1:0] action,
  input  logic       device_id,
  input  logic [7:0] reg_addr,
  input  logic [7:0] tx_byte,
  input  logic       has_data,
  input  logic       opens,
  input  logic       closes,
  input  logic [7:0] reply_cmd,
  input  logic [7:0] reply_data,
  input  logic       rsp_ready,
  output dp_status_t status,
  output logic       rsp_valid,
  output logic       cmd_sent,
  output logic [7:0] cmd_byte,
  output logic       data_sent,
  output logic [7:0] rx_byte,
  output logic [1:0] select_low,
  output logic       ignored,
  output logic       sck,
  output logic       mosi
);

  // configuration
  logic       enable;
  logic [7:0] write_prefix;
  logic [7:0] read_prefix;
  logic [7:0] address_mask;

  // latched item
  logic [1:0] item_action;
  logic       item_dev;
  logic [7:0] item_addr;
  logic [7:0] item_tx;
  logic       item_has_data;
  logic       item_opens;
  logic       item_closes;
  logic [7:0] item_reply_cmd;
  logic [7:0] item_reply_data;
  logic       item_enable;

  // transfer state
  logic [NUM_SELECTS-1:0] select_lines;
  logic [7:0]             shift_out;
  logic [7:0]             shift_in;
  logic [7:0]             miso_sh;
  logic [3:0]             bit_count;
  logic                   cmd_sent_r;
  logic [7:0]             cmd_byte_r;
  logic                   data_sent_r;

  logic                   reg_item;
  logic [NUM_SELECTS-1:0] dev_bit;
  logic [7:0]             cmd_value;
  logic [NUM_SELECTS+1:0] sel_pad;

  function automatic logic [1:0] dev_bit_pad(input logic [NUM_SELECTS-1:0] bits);
    logic [NUM_SELECTS+1:0] wide;
    wide = {2'b00, bits};
    return wide[1:0];
  endfunction

  assign reg_item  = (item_action == ACT_WRITE) || (item_action == ACT_READ);
  assign cmd_value = ((item_action == ACT_WRITE) ? write_prefix : read_prefix)
                     | (address_mask & item_addr);
  assign sel_pad   = {2'b00, ~select_lines};

  always_comb begin
    for (int i = 0; i < NUM_SELECTS; i++) begin
      dev_bit[i] = (32'(item_dev) == i);
    end
  end

  assign status.enable   = item_enable;
  assign status.do_cmd   = reg_item && item_opens;
  assign status.do_data  = item_has_data;
  assign status.last_bit = (bit_count == LAST_BIT);
  assign status.out_full = rsp_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable       <= 1'b0;
      write_prefix <= 8'h20;
      read_prefix  <= 8'h00;
      address_mask <= 8'h1F;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLE:       enable       <= cfg_data[0];
        CFG_WRITE_PREFIX: write_prefix <= cfg_data;
        CFG_READ_PREFIX:  read_prefix  <= cfg_data;
        CFG_ADDR_MASK:    address_mask <= cfg_data;
        default:          ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      select_lines <= SEL_ALL;
      sck          <= 1'b0;
      mosi         <= 1'b0;
      bit_count    <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (op)
        DP_START_CMD: begin
          select_lines <= select_lines & ~dev_bit;
          bit_count    <= '0;
        end
        DP_START_DATA: begin
          sck       <= 1'b0;
          bit_count <= '0;
        end
        DP_BIT_LO: begin
          sck  <= 1'b0;
          mosi <= shift_out[7];
        end
        DP_BIT_HI: begin
          sck       <= 1'b1;
          bit_count <= bit_count + 4'd1;
        end
        DP_FINISH: begin
          sck       <= 1'b0;
          rsp_valid <= 1'b1;
          if (item_enable && reg_item && item_closes) begin
            select_lines <= select_lines | dev_bit;
          end
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    unique case (op)
      DP_LOAD: begin
        item_action     <= action;
        item_dev        <= device_id;
        item_addr       <= reg_addr;
        item_tx         <= tx_byte;
        item_has_data   <= has_data;
        item_opens      <= opens;
        item_closes     <= closes;
        item_reply_cmd  <= reply_cmd;
        item_reply_data <= reply_data;
        item_enable     <= enable;
        cmd_sent_r      <= 1'b0;
        cmd_byte_r      <= 8'h00;
        data_sent_r     <= 1'b0;
      end
      DP_START_CMD: begin
        shift_out  <= cmd_value;
        miso_sh    <= item_reply_cmd;
        cmd_sent_r <= 1'b1;
        cmd_byte_r <= cmd_value;
      end
      DP_START_DATA: begin
        shift_out   <= item_tx;
        miso_sh     <= item_reply_data;
        data_sent_r <= 1'b1;
      end
      DP_BIT_HI: begin
        // sample MISO on the rising edge, advance all three shifters
        shift_in  <= {shift_in[6:0], miso_sh[7]};
        miso_sh   <= {miso_sh[6:0], 1'b0};
        shift_out <= {shift_out[6:0], 1'b0};
      end
      DP_FINISH: begin
        cmd_sent   <= cmd_sent_r;
        cmd_byte   <= cmd_byte_r;
        data_sent  <= data_sent_r;
        rx_byte    <= data_sent_r ? shift_in : 8'h00;
        ignored    <= !item_enable;
        select_low <= (item_enable && reg_item && item_closes)
                      ? sel_pad[1:0] & ~dev_bit_pad(dev_bit) : sel_pad[1:0];
      end
      default: ;
    endcase
  end

endmodule

@@ src/spi_register_access_master_core.sv @@
// Top level of the SPI mode 0 register-access master.
// Instantiates spirm_ctrl and spirm_datapath; uses spirm_pkg.

// One request produces exactly one response. A request that sends nothing, or
// any request while enable is 0, passes from acceptance through the dispatch
// and finish states to the response. Each byte sent adds a low and a high SCK
// phase per bit, and a second byte adds one more load step. A new request is
// accepted only from the cycle after the previous one has been written to the
// response register. A response that is not yet taken holds back the end of
// the following request only, until the cycle after its transfer.
module spi_register_access_master_core import spirm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       req_valid,
  output logic       req_ready,
  input  logic [1:0] action,
  input  logic       device_id,
  input  logic [7:0] reg_addr,
  input  logic [7:0] tx_byte,
  input  logic       has_data,
  input  logic       opens,
  input  logic       closes,
  input  logic [7:0] reply_cmd,
  input  logic [7:0] reply_data,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output logic       cmd_sent,
  output logic [7:0] cmd_byte,
  output logic       data_sent,
  output logic [7:0] rx_byte,
  output logic [1:0] select_low,
  output logic       ignored
);

  dp_op_t     op;
  dp_status_t status;
  logic       sck;
  logic       mosi;

  spirm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .status    (status),
    .op        (op)
  );

  spirm_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .op         (op),
    .action     (action),
    .device_id  (device_id),
    .reg_addr   (reg_addr),
    .tx_byte    (tx_byte),
    .has_data   (has_data),
    .opens      (opens),
    .closes     (closes),
    .reply_cmd  (reply_cmd),
    .reply_data (reply_data),
    .rsp_ready  (rsp_ready),
    .status     (status),
    .rsp_valid  (rsp_valid),
    .cmd_sent   (cmd_sent),
    .cmd_byte   (cmd_byte),
    .data_sent  (data_sent),
    .rx_byte    (rx_byte),
    .select_low (select_low),
    .ignored    (ignored),
    .sck        (sck),
    .mosi       (mosi)
  );

  // SCK rests low between transfers
  a_sck_idle_low: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> !sck)
    else $error("SCK high while idle");

  // MOSI is settled before SCK rises
  a_mosi_setup: assert property (@(posedge clk) disable iff (rst)
    $rose(sck) |-> $stable(mosi))
    else $error("MOSI changed with rising SCK");

  a_ignored_quiet: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && ignored |-> !cmd_sent && !data_sent && cmd_byte == 8'h00)
    else $error("dropped request reports bytes");

  a_no_cmd_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !cmd_sent |-> cmd_byte == 8'h00)
    else $error("command byte without command");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second request taken while busy");

endmodule
